/* rtl/core/dbpc_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants for the dual button press classifier
// no dependencies; every other file of the block depends on this package
package dbpc_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int CFG_WIDTH   = 16;
  localparam int HOLD_OUT_W  = 16;
  // width that holds both a counter and a threshold for compares
  localparam int CMP_W = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;
  localparam int ADDR_W = 4;

  typedef logic [COUNT_WIDTH-1:0] cnt_t;
  typedef logic [CFG_WIDTH-1:0]   cfgv_t;
  typedef logic [CMP_W-1:0]       cmp_t;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_SHORT = 2'd1,
    EV_LONG  = 2'd2
  } ev_t;

  typedef enum logic [1:0] {
    REG_DEBOUNCE   = 2'd0,
    REG_LONG_LEFT  = 2'd1,
    REG_LONG_RIGHT = 2'd2,
    REG_UNUSED     = 2'd3
  } reg_idx_t;

  localparam cfgv_t DEBOUNCE_RST   = CFG_WIDTH'(3);
  localparam cfgv_t LONG_LEFT_RST  = CFG_WIDTH'(300);
  localparam cfgv_t LONG_RIGHT_RST = CFG_WIDTH'(100);

  typedef struct packed {
    cfgv_t debounce;
    cfgv_t long_left;
    cfgv_t long_right;
  } cfg_t;

  // what one lane found for the current tick
  typedef struct packed {
    ev_t  ev;
    logic down;
    cnt_t hold;
  } lane_res_t;

endpackage

/* rtl/core/dbpc_if.sv */
`timescale 1ns / 1ps
// valid/ready channel interfaces for the tick input and the result output
// depends on dbpc_pkg for the event type and the hold width
interface dbpc_in_if;
  logic valid;
  logic ready;
  logic left_pressed;
  logic right_pressed;

  modport source (output valid, left_pressed, right_pressed, input ready);
  modport sink   (input valid, left_pressed, right_pressed, output ready);
endinterface

interface dbpc_out_if;
  logic                            valid;
  logic                            ready;
  dbpc_pkg::ev_t                   left_event;
  logic                            kill_request;
  dbpc_pkg::ev_t                   right_event;
  logic [dbpc_pkg::HOLD_OUT_W-1:0] left_hold_ticks;
  logic                            left_down;
  logic                            right_down;

  modport source (output valid, left_event, kill_request, right_event, left_hold_ticks,
                  left_down, right_down, input ready);
  modport sink   (input valid, left_event, kill_request, right_event, left_hold_ticks,
                  left_down, right_down, output ready);
endinterface

/* rtl/core/dbpc_cfg.sv */
`timescale 1ns / 1ps
// apb-style register file for debounce and long-press thresholds
// depends on dbpc_pkg
module dbpc_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dbpc_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output dbpc_pkg::cfg_t                cfg
);
  import dbpc_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce   <= DEBOUNCE_RST;
      cfg_r.long_left  <= LONG_LEFT_RST;
      cfg_r.long_right <= LONG_RIGHT_RST;
    end else if (wr) begin
      case (idx)
        REG_DEBOUNCE:   cfg_r.debounce   <= pwdata[CFG_WIDTH-1:0];
        REG_LONG_LEFT:  cfg_r.long_left  <= pwdata[CFG_WIDTH-1:0];
        REG_LONG_RIGHT: cfg_r.long_right <= pwdata[CFG_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_DEBOUNCE:   prdata = 32'(cfg_r.debounce);
      REG_LONG_LEFT:  prdata = 32'(cfg_r.long_left);
      REG_LONG_RIGHT: prdata = 32'(cfg_r.long_right);
      default:        prdata = 32'd0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

/* rtl/core/dbpc_lane.sv */
`timescale 1ns / 1ps
// one button lane: debounce, hold counter, short/long classification
// depends on dbpc_pkg
module dbpc_lane (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  accept,
  input  logic                  sample,
  input  dbpc_pkg::cfgv_t       debounce,
  input  dbpc_pkg::cfgv_t       long_ticks,
  output dbpc_pkg::lane_res_t   res
);
  import dbpc_pkg::*;

  localparam cnt_t CNT_MAX = {COUNT_WIDTH{1'b1}};

  logic raw_r, raw_nxt;
  logic state_r, state_nxt;
  logic latched_r, latched_nxt;
  cnt_t stable_r, stable_nxt;
  cnt_t hold_r, hold_nxt;
  ev_t  ev_nxt;

  always_comb begin
    logic released;
    cnt_t stable_inc;
    released    = 1'b0;
    raw_nxt     = raw_r;
    state_nxt   = state_r;
    latched_nxt = latched_r;
    stable_nxt  = stable_r;
    hold_nxt    = hold_r;
    ev_nxt      = EV_NONE;
    stable_inc  = (stable_r == CNT_MAX) ? stable_r : stable_r + 1'b1;

    if (state_r && hold_r != CNT_MAX) hold_nxt = hold_r + 1'b1;

    if (sample != raw_r) begin
      raw_nxt    = sample;
      stable_nxt = '0;
    end else begin
      stable_nxt = stable_inc;
      if (sample != state_r && cmp_t'(stable_inc) >= cmp_t'(debounce)) begin
        state_nxt = sample;
        hold_nxt  = '0;
        if (sample) latched_nxt = 1'b0;
        else        released    = 1'b1;
      end
    end

    if (released && !latched_nxt) begin
      ev_nxt = EV_SHORT;
    end else if (state_nxt && !latched_nxt && cmp_t'(hold_nxt) >= cmp_t'(long_ticks)) begin
      ev_nxt      = EV_LONG;
      latched_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_r     <= 1'b0;
      state_r   <= 1'b0;
      latched_r <= 1'b0;
      stable_r  <= '0;
      hold_r    <= '0;
    end else if (accept) begin
      raw_r     <= raw_nxt;
      state_r   <= state_nxt;
      latched_r <= latched_nxt;
      stable_r  <= stable_nxt;
      hold_r    <= hold_nxt;
    end
  end

  assign res.ev   = ev_nxt;
  assign res.down = state_nxt;
  assign res.hold = hold_nxt;

  a_long_latches: assert property (@(posedge clk) disable iff (!rst_n)
    accept && ev_nxt == EV_LONG |=> latched_r && state_r)
    else $error("long event without latch");

  a_short_releases: assert property (@(posedge clk) disable iff (!rst_n)
    accept && ev_nxt == EV_SHORT |=> !state_r && hold_r == '0)
    else $error("short event without release");

endmodule

/* rtl/core/dbpc_merge.sv */
`timescale 1ns / 1ps
// merges both lane results into one result beat held in an output register
// depends on dbpc_pkg
module dbpc_merge (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   accept,
  input  dbpc_pkg::lane_res_t    left_res,
  input  dbpc_pkg::lane_res_t    right_res,
  input  logic                   out_ready,
  output logic                   out_valid,
  output logic                   room,
  output dbpc_pkg::ev_t          left_event,
  output logic                   kill_request,
  output dbpc_pkg::ev_t          right_event,
  output logic [dbpc_pkg::HOLD_OUT_W-1:0] left_hold_ticks,
  output logic                   left_down,
  output logic                   right_down
);
  import dbpc_pkg::*;

  localparam cmp_t HOLD_TOP = cmp_t'({HOLD_OUT_W{1'b1}});

  logic valid_r, valid_nxt;
  ev_t  lev_r, rev_r;
  logic kill_r, ldown_r, rdown_r;
  logic [HOLD_OUT_W-1:0] hold_r, hold_nxt;

  always_comb begin
    cmp_t h;
    h = left_res.down ? cmp_t'(left_res.hold) : '0;
    // hold clamps to the output width when the counter is wider
    hold_nxt = (h > HOLD_TOP) ? HOLD_TOP[HOLD_OUT_W-1:0] : h[HOLD_OUT_W-1:0];
  end

  assign room      = !valid_r || out_ready;
  assign valid_nxt = accept ? 1'b1 : (out_ready ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      lev_r   <= left_res.ev;
      rev_r   <= right_res.ev;
      kill_r  <= (left_res.ev == EV_LONG);
      hold_r  <= hold_nxt;
      ldown_r <= left_res.down;
      rdown_r <= right_res.down;
    end
  end

  assign out_valid       = valid_r;
  assign left_event      = lev_r;
  assign kill_request    = kill_r;
  assign right_event     = rev_r;
  assign left_hold_ticks = hold_r;
  assign left_down       = ldown_r;
  assign right_down      = rdown_r;

  a_kill_is_long: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (kill_r == (lev_r == EV_LONG)))
    else $error("kill request out of step with left event");

  a_hold_needs_down: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && hold_r != '0 |-> ldown_r)
    else $error("left hold reported while released");

endmodule

/* rtl/core/dual_button_press_classifier_unit.sv */
`timescale 1ns / 1ps
// top level of the dual button press classifier: two button lanes, merge, registers
// depends on dbpc_pkg, dbpc_if, dbpc_cfg, dbpc_lane, dbpc_merge
//
//   channel   dir   handshake        beat contents
//   in_ch     in    valid/ready      left_pressed, right_pressed (one poll tick)
//   out_ch    out   valid/ready      left/right event, kill, left hold, both levels
//   psel..    in    apb, pready=1    debounce 0x0, long left 0x4, long right 0x8
//
// one tick per clock unless out_ch stalls: each lane updates its state at the edge
// the beat is taken, and the result is registered at that same edge and offered
// from the next cycle. a new tick is taken while a result waits, as long as the
// register drains that cycle. rst_n is synchronous, active low; it clears lane
// state and out valid and restores the reset thresholds.
module dual_button_press_classifier_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  dbpc_in_if.sink                     in_ch,
  dbpc_out_if.source                  out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dbpc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import dbpc_pkg::*;

  cfg_t      cfg;
  lane_res_t left_res, right_res;
  logic      accept, room;

  assign in_ch.ready = room;
  assign accept      = in_ch.valid && room;

  dbpc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dbpc_lane u_left (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .sample     (in_ch.left_pressed),
    .debounce   (cfg.debounce),
    .long_ticks (cfg.long_left),
    .res        (left_res)
  );

  dbpc_lane u_right (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .sample     (in_ch.right_pressed),
    .debounce   (cfg.debounce),
    .long_ticks (cfg.long_right),
    .res        (right_res)
  );

  dbpc_merge u_merge (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept          (accept),
    .left_res        (left_res),
    .right_res       (right_res),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .room            (room),
    .left_event      (out_ch.left_event),
    .kill_request    (out_ch.kill_request),
    .right_event     (out_ch.right_event),
    .left_hold_ticks (out_ch.left_hold_ticks),
    .left_down       (out_ch.left_down),
    .right_down      (out_ch.right_down)
  );

endmodule
